[hw/rtl/lmts_pkg.sv]
// shared types, codes and constants for the lcd mode timing sequencer
`timescale 1ns / 1ps

package lmts_pkg;

    // field widths
    localparam int LINE_W = 8;
    localparam int DOT_W  = 10;
    localparam int DATA_W = 8;
    localparam int ADDR_W = 16;

    // default line limits
    localparam int DEF_VISIBLE_LINES = 144;
    localparam int DEF_LAST_LINE     = 153;

    // mode durations in dots
    localparam logic [DOT_W-1:0] OAM_DOTS  = 10'd80;
    localparam logic [DOT_W-1:0] VRAM_DOTS = 10'd172;
    localparam logic [DOT_W-1:0] HBL_DOTS  = 10'd204;
    localparam logic [DOT_W-1:0] LINE_DOTS = 10'd456;
    localparam logic [DOT_W-1:0] DOT_MAX   = 10'd1023;

    // stat bit that enables the lcd interrupt on vblank entry
    localparam int STAT_VBL_IRQ_BIT = 4;

    // register addresses
    localparam logic [ADDR_W-1:0] ADDR_LCDC = 16'hFF40;
    localparam logic [ADDR_W-1:0] ADDR_STAT = 16'hFF41;
    localparam logic [ADDR_W-1:0] ADDR_SCY  = 16'hFF42;
    localparam logic [ADDR_W-1:0] ADDR_SCX  = 16'hFF43;
    localparam logic [ADDR_W-1:0] ADDR_LY   = 16'hFF44;
    localparam logic [ADDR_W-1:0] ADDR_LYC  = 16'hFF45;

    // item opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // display modes
    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_VRAM   = 2'd3
    } t_mode;

    // input beat
    typedef struct packed {
        logic [1:0]        opcode;
        logic [7:0]        elapsed_cycles;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } t_in_beat;

    // result beat
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [1:0]        current_mode;
        logic [LINE_W-1:0] current_line;
        logic              vblank_irq;
        logic              lcd_stat_irq;
        logic              frame_done;
    } t_out_beat;

    // pulses raised by one tick
    typedef struct packed {
        logic vblank_irq;
        logic lcd_stat_irq;
        logic frame_done;
    } t_tick_evt;

endpackage

[hw/rtl/lmts_timing.sv]
// dot counter, line counter and mode state machine
`timescale 1ns / 1ps

module lmts_timing
    import lmts_pkg::*;
#(
    parameter int VISIBLE_LINES = DEF_VISIBLE_LINES,
    parameter int LAST_LINE     = DEF_LAST_LINE
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tick,
    input  logic [7:0]        i_cycles,
    input  logic              i_stat_irq_en,
    output t_mode             o_mode_after,
    output logic [LINE_W-1:0] o_line_after,
    output logic [LINE_W-1:0] o_line,
    output t_tick_evt         o_evt
);

    t_mode             r_mode, n_mode;
    logic [DOT_W-1:0]  r_dot, n_dot;
    logic [LINE_W-1:0] r_line, n_line;

    logic [DOT_W:0]    sum;
    logic [DOT_W-1:0]  dot_sat;
    logic [LINE_W:0]   line_inc;
    logic              enter_vbl;

    // saturating dot add
    assign sum      = {1'b0, r_dot} + {{(DOT_W + 1 - 8){1'b0}}, i_cycles};
    assign dot_sat  = sum[DOT_W] ? DOT_MAX : sum[DOT_W-1:0];
    assign line_inc = {1'b0, r_line} + {{LINE_W{1'b0}}, 1'b1};

    // next state
    always_comb begin
        n_mode = r_mode;
        n_dot  = dot_sat;
        n_line = r_line;
        unique case (r_mode)
            MODE_HBLANK: begin
                if (dot_sat >= HBL_DOTS) begin
                    n_dot  = dot_sat - HBL_DOTS;
                    n_line = line_inc[LINE_W-1:0];
                    n_mode = (line_inc[LINE_W-1:0] == LINE_W'(VISIBLE_LINES))
                             ? MODE_VBLANK : MODE_OAM;
                end
            end
            MODE_VBLANK: begin
                if (dot_sat >= LINE_DOTS) begin
                    n_dot = dot_sat - LINE_DOTS;
                    if (line_inc > (LINE_W + 1)'(LAST_LINE)) begin
                        n_mode = MODE_OAM;
                        n_line = '0;
                    end else begin
                        n_line = line_inc[LINE_W-1:0];
                    end
                end
            end
            MODE_OAM: begin
                if (dot_sat >= OAM_DOTS) begin
                    n_dot  = dot_sat - OAM_DOTS;
                    n_mode = MODE_VRAM;
                end
            end
            MODE_VRAM: begin
                if (dot_sat >= VRAM_DOTS) begin
                    n_dot  = dot_sat - VRAM_DOTS;
                    n_mode = MODE_HBLANK;
                end
            end
            default: begin
                n_mode = MODE_HBLANK;
            end
        endcase
    end

    // pulses on vblank entry
    always_comb begin
        enter_vbl          = i_tick && (r_mode == MODE_HBLANK) && (n_mode == MODE_VBLANK);
        o_evt.vblank_irq   = enter_vbl;
        o_evt.frame_done   = enter_vbl;
        o_evt.lcd_stat_irq = enter_vbl && i_stat_irq_en;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_HBLANK;
            r_dot  <= '0;
            r_line <= '0;
        end else if (i_tick) begin
            r_mode <= n_mode;
            r_dot  <= n_dot;
            r_line <= n_line;
        end
    end

    // values seen after this item
    assign o_mode_after = i_tick ? n_mode : r_mode;
    assign o_line_after = i_tick ? n_line : r_line;
    assign o_line       = r_line;

    // vblank entry only from hblank
    a_frame_from_hblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evt.frame_done |-> (r_mode == MODE_HBLANK))
        else $error("frame pulse outside hblank");

    // no pulses without a tick
    a_no_evt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_tick |-> (o_evt == '0))
        else $error("pulse without tick");

    // a mode change always takes its duration off the dot counter
    a_mode_step_dot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tick && (n_mode != r_mode)) |-> (n_dot < dot_sat))
        else $error("mode change without dot subtraction");

endmodule

[hw/rtl/lmts_regfile.sv]
// control, stat, scroll and compare registers with bus decode
`timescale 1ns / 1ps

module lmts_regfile
    import lmts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [LINE_W-1:0] i_line,
    output logic [DATA_W-1:0] o_rdata,
    output logic              o_stat_irq_en
);

    logic [DATA_W-1:0] r_lcdc;
    logic [DATA_W-1:0] r_stat;
    logic [DATA_W-1:0] r_scy;
    logic [DATA_W-1:0] r_scx;
    logic [DATA_W-1:0] r_lyc;

    // register writes, line register is read only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcdc <= '0;
            r_stat <= '0;
            r_scy  <= '0;
            r_scx  <= '0;
            r_lyc  <= '0;
        end else if (i_wr_en) begin
            unique case (i_addr)
                ADDR_LCDC: r_lcdc <= i_wdata;
                ADDR_STAT: r_stat <= i_wdata;
                ADDR_SCY:  r_scy  <= i_wdata;
                ADDR_SCX:  r_scx  <= i_wdata;
                ADDR_LYC:  r_lyc  <= i_wdata;
                default: begin
                end
            endcase
        end
    end

    // read decode
    always_comb begin
        unique case (i_addr)
            ADDR_LCDC: o_rdata = r_lcdc;
            ADDR_STAT: o_rdata = r_stat;
            ADDR_SCY:  o_rdata = r_scy;
            ADDR_SCX:  o_rdata = r_scx;
            ADDR_LY:   o_rdata = i_line;
            ADDR_LYC:  o_rdata = r_lyc;
            default:   o_rdata = '0;
        endcase
    end

    assign o_stat_irq_en = r_stat[STAT_VBL_IRQ_BIT];

endmodule

[hw/rtl/lcd_mode_timing_sequencer.sv]
// top level of the lcd mode timing sequencer with result register
`timescale 1ns / 1ps
//
// Keeps the mode and line timing of a handheld lcd controller and serves
// its register bus.
// Input channel (i_in_valid / o_in_ready / i_in): one beat is a tick that
// adds elapsed cycles to the dot counter, a register read, a register
// write (0xFF40..0xFF45; the line register is read only) or a no-op.
// Output channel (o_out_valid / i_out_ready / o_out): exactly one result
// beat per input beat, in order: read data, mode and line after the item,
// and the vblank, lcd stat and frame done pulses.
// The state update and the result are computed in the accept cycle and
// the result sits in the output register next cycle.
// Throughput is one item per cycle while results are taken; the output
// register is the only stage, so a taken result frees it in the same
// cycle a new beat enters. When the receiver stalls with a result
// held, o_in_ready drops until it is taken; nothing is lost or repeated.
// Reset clears mode to hblank, dot and line counters and all registers
// to zero and empties the output register.
//

module lcd_mode_timing_sequencer
    import lmts_pkg::*;
#(
    parameter int VISIBLE_LINES = DEF_VISIBLE_LINES,
    parameter int LAST_LINE     = DEF_LAST_LINE
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out
);

    logic              in_acc;
    logic              tick_en;
    logic              wr_en;
    logic              rd_sel;
    t_mode             mode_after;
    logic [LINE_W-1:0] line_after;
    logic [LINE_W-1:0] line_cur;
    t_tick_evt         evt;
    logic              stat_irq_en;
    logic [DATA_W-1:0] rdata;

    logic      r_out_valid, n_out_valid;
    t_out_beat r_out, n_out;

    // handshake
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;
    assign tick_en    = in_acc && (i_in.opcode == OP_TICK);
    assign wr_en      = in_acc && (i_in.opcode == OP_WRITE);
    assign rd_sel     = (i_in.opcode == OP_READ);

    lmts_timing #(
        .VISIBLE_LINES (VISIBLE_LINES),
        .LAST_LINE     (LAST_LINE)
    ) u_timing (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tick        (tick_en),
        .i_cycles      (i_in.elapsed_cycles),
        .i_stat_irq_en (stat_irq_en),
        .o_mode_after  (mode_after),
        .o_line_after  (line_after),
        .o_line        (line_cur),
        .o_evt         (evt)
    );

    lmts_regfile u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr_en       (wr_en),
        .i_addr        (i_in.address),
        .i_wdata       (i_in.write_data),
        .i_line        (line_cur),
        .o_rdata       (rdata),
        .o_stat_irq_en (stat_irq_en)
    );

    // result beat
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (in_acc) begin
            n_out_valid        = 1'b1;
            n_out.read_data    = rd_sel ? rdata : '0;
            n_out.current_mode = mode_after;
            n_out.current_line = line_after;
            n_out.vblank_irq   = evt.vblank_irq;
            n_out.lcd_stat_irq = evt.lcd_stat_irq;
            n_out.frame_done   = evt.frame_done;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // an accepted beat always yields a result next cycle
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out_valid)
        else $error("accepted beat produced no result");

    // frame done is reported in vblank
    a_frame_in_vblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.frame_done) |-> (o_out.current_mode == MODE_VBLANK))
        else $error("frame done outside vblank");

    // stat interrupt only with vblank interrupt
    a_stat_with_vblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.lcd_stat_irq) |-> o_out.vblank_irq)
        else $error("stat irq without vblank irq");

endmodule
